@@ hdl/spp_pkg.sv @@
// Shared types and constants of the stereo ping-pong delay.
package spp_pkg;

    localparam int DEPTH       = 262144;
    localparam int SAMPLE_BITS = 24;
    localparam int ADDR_BITS   = $clog2(DEPTH);

    localparam int DELAY_BITS    = 18;
    localparam int MIX_BITS      = 16;
    localparam int FB_BITS       = 15;
    localparam int CFG_DATA_BITS = 18;
    localparam int CFG_IDX_BITS  = 2;

    localparam int DELAY_RESET = 24000;
    localparam int FRAC_BITS   = 15;
    localparam int ROUND_HALF  = 1 << (FRAC_BITS - 1);
    localparam int MIX_ONE     = 1 << FRAC_BITS;
    localparam int MIX_BYPASS  = 3;
    localparam int FB_MAX      = 30801;
    localparam int W_CROSS     = 23593;
    localparam int W_SAME      = 9175;

    localparam logic [CFG_IDX_BITS-1:0] CFG_DELAY    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WET_MIX  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FEEDBACK = 2'd2;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    typedef struct packed {
        t_sample left_in;
        t_sample right_in;
    } t_in_item;

    typedef struct packed {
        t_sample left_out;
        t_sample right_out;
    } t_out_item;

    typedef struct packed {
        logic                 rd_en;
        logic                 rd_ok;
        logic                 blend_en;
        logic                 mix_en;
        logic                 wr_en;
        logic [ADDR_BITS-1:0] rd_addr;
        logic [ADDR_BITS-1:0] wr_addr;
        logic [MIX_BITS-1:0]  mix;
        logic [FB_BITS-1:0]   fb;
    } t_lane_ctrl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_BLEND,
        S_MIX,
        S_DONE
    } t_state;

endpackage

@@ hdl/stereo_ping_pong_delay_top.sv @@
// Top level of the stereo ping-pong feedback delay with two channel lanes.
// After the input transfer come store read, blend and mix; the result is then registered at the
// output with the write-back once the output is free. A new item is taken only after the last is
// done, set by each lane's store read-modify-write; a stalled result holds off the next transfer.
// Reset is synchronous and active low; the stores need no clearing pass, since a
// fill flag makes entries not yet written since reset read as zero.
module stereo_ping_pong_delay_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [spp_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [spp_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  spp_pkg::t_in_item                   i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output spp_pkg::t_out_item                  o_out
);
    import spp_pkg::*;

    t_state                r_state;
    t_state                n_state;
    logic [DELAY_BITS-1:0] r_delay;
    logic [MIX_BITS-1:0]   r_wet_mix;
    logic [FB_BITS-1:0]    r_fb;
    logic [ADDR_BITS-1:0]  r_wp;
    logic                  r_full;
    logic                  r_bypass;
    t_in_item              r_dry;

    logic                 accept;
    logic                 done;
    logic                 out_free;
    logic [31:0]          dly;
    logic [31:0]          wp32;
    logic [31:0]          rd32;
    logic [MIX_BITS-1:0]  mix_c;
    logic [FB_BITS-1:0]   fb_c;
    t_lane_ctrl           ctrl;
    t_sample              delayed_left;
    t_sample              delayed_right;
    t_sample              wet_left;
    t_sample              wet_right;

    always_comb begin
        dly = 32'(r_delay);
        if (dly == 32'd0) begin
            dly = 32'd1;
        end
        if (dly > 32'(DEPTH - 1)) begin
            dly = 32'(DEPTH - 1);
        end
        wp32 = 32'(r_wp);
        if (wp32 >= dly) begin
            rd32 = wp32 - dly;
        end else begin
            rd32 = wp32 + 32'(DEPTH) - dly;
        end
    end

    assign mix_c = (r_wet_mix > MIX_BITS'(MIX_ONE)) ? MIX_BITS'(MIX_ONE) : r_wet_mix;
    assign fb_c  = (r_fb > FB_BITS'(FB_MAX)) ? FB_BITS'(FB_MAX) : r_fb;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_BLEND;
                end
            end
            S_BLEND: begin
                n_state = S_MIX;
            end
            S_MIX: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        accept = (r_state == S_IDLE) && i_in_valid;
        done   = (r_state == S_DONE) && out_free;
        ctrl.rd_en    = accept;
        ctrl.rd_ok    = r_full || (rd32[ADDR_BITS-1:0] < r_wp);
        ctrl.blend_en = (r_state == S_BLEND);
        ctrl.mix_en   = (r_state == S_MIX);
        ctrl.wr_en    = done && !r_bypass;
        ctrl.rd_addr  = rd32[ADDR_BITS-1:0];
        ctrl.wr_addr  = r_wp;
        ctrl.mix      = mix_c;
        ctrl.fb       = fb_c;
        o_in_stall    = (r_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_delay   <= DELAY_BITS'(DELAY_RESET);
            r_wet_mix <= '0;
            r_fb      <= '0;
            r_wp      <= '0;
            r_full    <= 1'b0;
            r_bypass  <= 1'b1;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DELAY:    r_delay   <= i_cfg_data[DELAY_BITS-1:0];
                    CFG_WET_MIX:  r_wet_mix <= i_cfg_data[MIX_BITS-1:0];
                    CFG_FEEDBACK: r_fb      <= i_cfg_data[FB_BITS-1:0];
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                r_bypass <= (mix_c <= MIX_BITS'(MIX_BYPASS));
            end
            if (ctrl.wr_en) begin
                if (r_wp == ADDR_BITS'(DEPTH - 1)) begin
                    r_wp   <= '0;
                    r_full <= 1'b1;
                end else begin
                    r_wp <= r_wp + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_dry <= i_in;
        end
    end

    spp_lane u_lane_left (
        .i_clk     (i_clk),
        .i_ctrl    (ctrl),
        .i_dry     (r_dry.left_in),
        .i_cross   (delayed_right),
        .o_delayed (delayed_left),
        .o_out     (wet_left)
    );

    spp_lane u_lane_right (
        .i_clk     (i_clk),
        .i_ctrl    (ctrl),
        .i_dry     (r_dry.right_in),
        .i_cross   (delayed_left),
        .o_delayed (delayed_right),
        .o_out     (wet_right)
    );

    spp_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (done),
        .i_bypass    (r_bypass),
        .i_dry       (r_dry),
        .i_wet_left  (wet_left),
        .i_wet_right (wet_right),
        .i_stall     (i_out_stall),
        .o_free      (out_free),
        .o_valid     (o_out_valid),
        .o_out       (o_out)
    );

endmodule

@@ hdl/spp_lane.sv @@
// One channel lane: delay store, ping-pong blend, feedback write and dry/wet mix.
module spp_lane (
    input  logic                i_clk,
    input  spp_pkg::t_lane_ctrl i_ctrl,
    input  spp_pkg::t_sample    i_dry,
    input  spp_pkg::t_sample    i_cross,
    output spp_pkg::t_sample    o_delayed,
    output spp_pkg::t_sample    o_out
);
    import spp_pkg::*;

    localparam int ACC_BITS = SAMPLE_BITS + 19;
    localparam logic signed [ACC_BITS-1:0] SAT_HI =
        {{(ACC_BITS - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] SAT_LO = ~SAT_HI;

    function automatic logic signed [ACC_BITS-1:0] round_q15(
        input logic signed [ACC_BITS-1:0] x
    );
        return (x + ACC_BITS'(ROUND_HALF)) >>> FRAC_BITS;
    endfunction

    function automatic t_sample sat_sample(input logic signed [ACC_BITS-1:0] x);
        logic signed [ACC_BITS-1:0] y;
        y = x;
        if (x > SAT_HI) begin
            y = SAT_HI;
        end else if (x < SAT_LO) begin
            y = SAT_LO;
        end
        return y[SAMPLE_BITS-1:0];
    endfunction

    t_sample r_store [DEPTH];
    t_sample r_rd_raw;
    logic    r_rd_ok;
    t_sample r_blend;
    t_sample r_fb_term;
    t_sample r_out;

    t_sample                     delayed;
    logic signed [ACC_BITS-1:0]  blend_acc;
    logic signed [ACC_BITS-1:0]  blend_r;
    logic signed [ACC_BITS-1:0]  fb_acc;
    logic signed [ACC_BITS-1:0]  fb_r;
    logic signed [ACC_BITS-1:0]  wet_acc;
    logic signed [ACC_BITS-1:0]  wet_r;
    logic signed [ACC_BITS-1:0]  wr_sum;
    logic [MIX_BITS-1:0]         dry_gain;

    // Entries not yet written since reset read as zero.
    assign delayed = r_rd_ok ? r_rd_raw : '0;

    assign blend_acc = ACC_BITS'(i_cross) * ACC_BITS'(W_CROSS)
                     + ACC_BITS'(delayed) * ACC_BITS'(W_SAME);
    assign blend_r   = round_q15(blend_acc);

    assign dry_gain = MIX_BITS'(MIX_ONE) - i_ctrl.mix;
    assign fb_acc   = ACC_BITS'(r_blend) * ACC_BITS'($signed({1'b0, i_ctrl.fb}));
    assign fb_r     = round_q15(fb_acc);
    assign wet_acc  = ACC_BITS'(i_dry) * ACC_BITS'($signed({1'b0, dry_gain}))
                    + ACC_BITS'(r_blend) * ACC_BITS'($signed({1'b0, i_ctrl.mix}));
    assign wet_r    = round_q15(wet_acc);

    assign wr_sum = ACC_BITS'(i_dry) + ACC_BITS'(r_fb_term);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_store[i_ctrl.wr_addr] <= sat_sample(wr_sum);
        end
        if (i_ctrl.rd_en) begin
            r_rd_raw <= r_store[i_ctrl.rd_addr];
            r_rd_ok  <= i_ctrl.rd_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.blend_en) begin
            r_blend <= blend_r[SAMPLE_BITS-1:0];
        end
        if (i_ctrl.mix_en) begin
            r_fb_term <= fb_r[SAMPLE_BITS-1:0];
            r_out     <= sat_sample(wet_r);
        end
    end

    assign o_delayed = delayed;
    assign o_out     = r_out;

endmodule

@@ hdl/spp_out.sv @@
// Output stage that merges the two lane results, or the dry pair in bypass.
module spp_out (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  logic               i_bypass,
    input  spp_pkg::t_in_item  i_dry,
    input  spp_pkg::t_sample   i_wet_left,
    input  spp_pkg::t_sample   i_wet_right,
    input  logic               i_stall,
    output logic               o_free,
    output logic               o_valid,
    output spp_pkg::t_out_item o_out
);
    import spp_pkg::*;

    logic      r_valid;
    t_out_item r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            if (i_bypass) begin
                r_out.left_out  <= i_dry.left_in;
                r_out.right_out <= i_dry.right_in;
            end else begin
                r_out.left_out  <= i_wet_left;
                r_out.right_out <= i_wet_right;
            end
        end
    end

    assign o_free  = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_out   = r_out;

endmodule

@@ tb/stereo_delay_checker.sv @@
`timescale 1ns / 100ps
// Checker for the stereo ping-pong delay: mirrors the registers, predicts every pair and compares.
module stereo_delay_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [spp_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [spp_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                               i_in_valid,
    input  logic                               i_in_stall,
    input  spp_pkg::t_in_item                  i_in,
    input  logic                               i_out_valid,
    input  logic                               i_out_stall,
    input  spp_pkg::t_out_item                 i_out,
    output int                                 o_fail_count,
    output int                                 o_pending,
    output int                                 o_checked
);
    import spp_pkg::*;

    logic [DELAY_BITS-1:0] delay_len;
    logic [MIX_BITS-1:0]   wet_mix;
    logic [FB_BITS-1:0]    fb_gain;
    t_sample               left_mem[int];
    t_sample               right_mem[int];
    int                    wr_ptr;
    t_out_item             expected_pairs[$];

    function automatic longint round_q15(longint v);
        return (v + ROUND_HALF) >>> FRAC_BITS;
    endfunction

    function automatic longint clip_sample(longint v);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // Advances the delay-line state and returns the stereo pair that the block should emit.
    function automatic t_out_item predict_pair(t_in_item x);
        longint    dl;
        longint    dr;
        longint    wl;
        longint    wr;
        longint    pl;
        longint    pr;
        int        mix;
        int        fb;
        int        dly;
        int        rd;
        t_out_item r;
        dl  = x.left_in;
        dr  = x.right_in;
        mix = (wet_mix > MIX_ONE) ? MIX_ONE : int'(wet_mix);
        fb  = (fb_gain > FB_MAX) ? FB_MAX : int'(fb_gain);
        if (mix <= MIX_BYPASS) begin
            r.left_out  = x.left_in;
            r.right_out = x.right_in;
            return r;
        end
        dly = (delay_len < 1) ? 1 : int'(delay_len);
        if (dly > DEPTH - 1) dly = DEPTH - 1;
        rd = (wr_ptr + DEPTH - dly) % DEPTH;
        wl = left_mem.exists(rd) ? longint'(left_mem[rd]) : 0;
        wr = right_mem.exists(rd) ? longint'(right_mem[rd]) : 0;
        pl = round_q15(W_CROSS * wr + W_SAME * wl);
        pr = round_q15(W_CROSS * wl + W_SAME * wr);
        left_mem[wr_ptr]  = t_sample'(clip_sample(dl + round_q15(pl * fb)));
        right_mem[wr_ptr] = t_sample'(clip_sample(dr + round_q15(pr * fb)));
        r.left_out  = t_sample'(clip_sample(round_q15(dl * (MIX_ONE - mix) + pl * mix)));
        r.right_out = t_sample'(clip_sample(round_q15(dr * (MIX_ONE - mix) + pr * mix)));
        wr_ptr = (wr_ptr + 1) % DEPTH;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            left_mem.delete();
            right_mem.delete();
            expected_pairs.delete();
            wr_ptr       = 0;
            delay_len    = DELAY_BITS'(DELAY_RESET);
            wet_mix      = '0;
            fb_gain      = '0;
            o_fail_count = 0;
            o_checked    = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DELAY: begin
                        delay_len = i_cfg_data[DELAY_BITS-1:0];
                    end
                    CFG_WET_MIX: begin
                        wet_mix = i_cfg_data[MIX_BITS-1:0];
                    end
                    CFG_FEEDBACK: begin
                        fb_gain = i_cfg_data[FB_BITS-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                expected_pairs.push_back(predict_pair(i_in));
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_pairs.size() == 0) begin
                    $error("Output transfer with nothing expected: left_out %0d, right_out %0d",
                           i_out.left_out, i_out.right_out);
                    o_fail_count++;
                end else begin
                    want = expected_pairs.pop_front();
                    o_checked++;
                    if (i_out.left_out !== want.left_out) begin
                        $error("left_out mismatch: expected %0d, actual %0d",
                               want.left_out, i_out.left_out);
                        o_fail_count++;
                    end
                    if (i_out.right_out !== want.right_out) begin
                        $error("right_out mismatch: expected %0d, actual %0d",
                               want.right_out, i_out.right_out);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = expected_pairs.size();
    end

endmodule

@@ tb/tb_stereo_ping_pong_delay_top.sv @@
`timescale 1ns / 100ps
// Testbench top for the stereo ping-pong delay: clock, reset, stimulus, idling and verdict.
module tb_stereo_ping_pong_delay_top;
    import spp_pkg::*;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;
    localparam int ITEMS      = 950;
    localparam int LATENCY    = 4;
    localparam int IDLE_LIMIT = 2000;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;
    logic                     i_in_valid;
    logic                     o_in_stall;
    t_in_item                 i_in;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    t_out_item                o_out;

    int fail_count;
    int pending;
    int checked;
    int sent;
    int settings;
    int stall_left  = 0;
    int idle_cycles = 0;
    bit no_idle;

    stereo_ping_pong_delay_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    stereo_delay_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in         (i_in),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out        (o_out),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (!no_idle && $urandom_range(0, 4) == 0) begin
            stall_left  <= $urandom_range(0, 4);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic t_sample pick_sample();
        case ($urandom_range(0, 7))
            0: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            1: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            2: return '0;
            3: return '1;
            4: return t_sample'(int'($urandom_range(0, 2000)) - 1000);
            default: return t_sample'($urandom);
        endcase
    endfunction

    task automatic send_pair(input t_sample l, input t_sample r);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_in.left_in   <= l;
        i_in.right_in  <= r;
        do @(posedge i_clk); while (o_in_stall);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (2 * LATENCY) @(negedge i_clk);
    endtask

    task automatic set_regs(input logic [CFG_DATA_BITS-1:0] dly,
                            input logic [CFG_DATA_BITS-1:0] mix,
                            input logic [CFG_DATA_BITS-1:0] fb);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_SPARE;
        i_cfg_data  <= CFG_DATA_BITS'($urandom);
        @(negedge i_clk);
        i_cfg_index <= CFG_DELAY;
        i_cfg_data  <= dly;
        @(negedge i_clk);
        i_cfg_index <= CFG_WET_MIX;
        i_cfg_data  <= mix;
        @(negedge i_clk);
        i_cfg_index <= CFG_FEEDBACK;
        i_cfg_data  <= fb;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        settings++;
    endtask

    initial begin
        logic [CFG_DATA_BITS-1:0] dly;
        logic [CFG_DATA_BITS-1:0] mix;
        logic [CFG_DATA_BITS-1:0] fb;
        t_sample                  hi;
        t_sample                  lo;
        int                       burst;
        hi          = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        lo          = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_DELAY;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_in        = '0;
        no_idle     = 1'b0;
        sent        = 0;
        settings    = 1;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings leave the block in bypass.
        send_pair(hi, lo);
        send_pair(lo, hi);
        send_pair('0, '1);

        // Zero delay acts as one, full wet, feedback above the cap.
        wait_for_results();
        set_regs('0, CFG_DATA_BITS'(MIX_ONE), 18'h07FFF);
        send_pair(hi, hi);
        send_pair(hi, hi);
        send_pair(lo, lo);
        send_pair(lo, hi);
        send_pair(hi, lo);
        send_pair('0, '0);

        // Wide writes are masked: wet mix above one and feedback above the cap.
        wait_for_results();
        set_regs(18'd2, 18'h1FFFF, 18'h3FFFF);
        send_pair(hi, lo);
        send_pair(lo, hi);
        send_pair(hi, hi);
        send_pair('1, '1);

        // Mix of three after masking bypasses and must not touch the stores.
        wait_for_results();
        set_regs(18'd5, 18'h20003, '0);
        send_pair(hi, hi);
        send_pair(lo, lo);
        send_pair('1, '0);

        // Smallest mix that is not bypass.
        wait_for_results();
        set_regs(18'd5, CFG_DATA_BITS'(MIX_BYPASS + 1), 18'h20064);
        send_pair(hi, lo);
        send_pair(lo, hi);
        send_pair(hi, hi);

        // Longest delay.
        wait_for_results();
        set_regs(CFG_DATA_BITS'(DEPTH - 1), CFG_DATA_BITS'(MIX_ONE / 2),
                 CFG_DATA_BITS'(FB_MAX));
        send_pair(hi, lo);
        send_pair(lo, hi);
        send_pair(pick_sample(), pick_sample());

        while (sent < ITEMS) begin
            if (sent > ITEMS - 120) no_idle <= 1'b1;
            case ($urandom_range(0, 9))
                0: dly = '0;
                1: dly = CFG_DATA_BITS'(DEPTH - 1);
                2: dly = CFG_DATA_BITS'($urandom);
                default: dly = CFG_DATA_BITS'($urandom_range(1, 48));
            endcase
            case ($urandom_range(0, 9))
                0: mix = CFG_DATA_BITS'($urandom_range(0, MIX_BYPASS));
                1: mix = CFG_DATA_BITS'($urandom_range(MIX_ONE, 18'h3FFFF));
                2: mix = CFG_DATA_BITS'(MIX_ONE);
                default: mix = CFG_DATA_BITS'($urandom_range(MIX_BYPASS + 1, MIX_ONE));
            endcase
            case ($urandom_range(0, 7))
                0: fb = '0;
                1: fb = CFG_DATA_BITS'($urandom_range(FB_MAX, 18'h3FFFF));
                2: fb = CFG_DATA_BITS'(FB_MAX);
                default: fb = CFG_DATA_BITS'($urandom_range(0, FB_MAX));
            endcase
            wait_for_results();
            set_regs(dly, mix, fb);
            burst = $urandom_range(30, 90);
            if (burst > ITEMS - sent) burst = ITEMS - sent;
            repeat (burst) send_pair(pick_sample(), pick_sample());
        end

        wait_for_results();
        $display("Checked %0d stereo transfers over %0d register settings,", checked, settings);
        $display("covering bypass, clamped delay, mix and feedback, masking and saturation.");
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
